// File: sv/psd_pkg.sv
// Shared types and constants for the point to segment distance block.
package psd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int DIST_W          = 25;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		CASE_BEYOND_B = 2'd0,
		CASE_BEFORE_A = 2'd1,
		CASE_PERP     = 2'd2,
		CASE_DEGEN    = 2'd3
	} nearest_case_t;

	// Control that walks down the cell chain next to each word.
	typedef struct packed {
		logic          valid;
		nearest_case_t kase;
	} psd_ctl_t;

endpackage

// File: sv/point_to_segment_distance.sv
// Top level: point to segment distance, front stages, divide and root cell chains, output skid.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------
//  input    | in_valid  | in_stall  | a_x a_y b_x b_y e_x e_y
//  output   | out_valid | out_stall | distance nearest_case
//
// Takes one word per cycle while in_stall is low. The divider chain has RW = 2*COORD_WIDTH + 2
// + 2*FRAC_BITS cells (one per quotient bit) and the root chain has QW = RW/2 cells (one per
// root bit).
// Reset clears only control registers (valid flags, case codes, skid flag); data registers come up with anything.
// When out_stall holds the output, one more word lands in a skid register; only then
// in_stall rises and the whole chain freezes.
module point_to_segment_distance import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] e_x,
	input  logic signed [COORD_WIDTH-1:0] e_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DIST_W-1:0]             distance,
	output logic [1:0]                    nearest_case
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;                   // squares, dots, divisor
	localparam int RW = PW + 2 * FRAC_BITS;       // radicand and quotient
	localparam int QW = RW / 2;                   // root
	localparam int MW = (QW > DIST_W) ? QW : DIST_W;

	logic en;

	// divider chain taps
	psd_ctl_t      d_ctl  [0:RW];
	logic [PW-1:0] d_rem  [0:RW];
	logic [RW-1:0] d_num  [0:RW];
	logic [RW-1:0] d_quot [0:RW];
	logic [PW-1:0] d_den  [0:RW];
	logic [PW-1:0] d_sb   [0:RW];

	// root chain taps
	psd_ctl_t      q_ctl  [0:QW];
	logic [RW-1:0] q_rad  [0:QW];
	logic [QW:0]   q_rem  [0:QW];
	logic [QW-1:0] q_root [0:QW];

	// output side
	logic              out_valid_q, skid_full_q;
	logic [DIST_W-1:0] out_dist_q, skid_dist_q, dist_c;
	nearest_case_t     out_case_q, skid_case_q;
	logic [MW-1:0]     root_ext;
	logic              take, arrive;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	psd_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.a_x     (a_x),
		.a_y     (a_y),
		.b_x     (b_x),
		.b_y     (b_y),
		.e_x     (e_x),
		.e_y     (e_y),
		.ctl     (d_ctl[0]),
		.rem0    (d_rem[0]),
		.num0    (d_num[0]),
		.den     (d_den[0]),
		.s_sel   (d_sb[0])
	);

	assign d_quot[0] = '0;

	// quotient = floor(cross^2 * 2^(2F) / |AB|^2), one bit per cell
	for (genvar i = 0; i < RW; i++) begin : g_div
		psd_div_cell #(
			.SW  (PW),
			.RW  (RW),
			.SB_W(PW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (d_ctl[i]),
			.rem_i (d_rem[i]),
			.num_i (d_num[i]),
			.quot_i(d_quot[i]),
			.den_i (d_den[i]),
			.sb_i  (d_sb[i]),
			.ctl_o (d_ctl[i+1]),
			.rem_o (d_rem[i+1]),
			.num_o (d_num[i+1]),
			.quot_o(d_quot[i+1]),
			.den_o (d_den[i+1]),
			.sb_o  (d_sb[i+1])
		);
	end

	// perpendicular case roots the quotient; the others root the scaled squared distance
	assign q_ctl[0]  = d_ctl[RW];
	assign q_rad[0]  = (d_ctl[RW].kase == CASE_PERP) ? d_quot[RW]
	                                                 : (RW'(d_sb[RW]) << (2 * FRAC_BITS));
	assign q_rem[0]  = '0;
	assign q_root[0] = '0;

	for (genvar j = 0; j < QW; j++) begin : g_sqrt
		psd_sqrt_cell #(
			.QW   (QW),
			.RAD_W(RW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (q_ctl[j]),
			.rad_i (q_rad[j]),
			.rem_i (q_rem[j]),
			.root_i(q_root[j]),
			.ctl_o (q_ctl[j+1]),
			.rad_o (q_rad[j+1]),
			.rem_o (q_rem[j+1]),
			.root_o(q_root[j+1])
		);
	end

	// saturate wide roots
	assign root_ext = MW'(q_root[QW]);
	assign dist_c   = (root_ext > MW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

	assign take   = out_valid_q && !out_stall;
	assign arrive = en && q_ctl[QW].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take)
				skid_full_q <= 1'b0;
		end else if (arrive) begin
			if (out_valid_q && !take)
				skid_full_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_dist_q <= skid_dist_q;
				out_case_q <= skid_case_q;
			end
		end else if (arrive) begin
			if (out_valid_q && !take) begin
				skid_dist_q <= dist_c;
				skid_case_q <= q_ctl[QW].kase;
			end else begin
				out_dist_q <= dist_c;
				out_case_q <= q_ctl[QW].kase;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign distance     = out_dist_q;
	assign nearest_case = out_case_q;

	// skid holds a word only behind a waiting output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid full without output word");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && out_stall) |=> skid_full_q)
		else $error("skid word lost under stall");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && out_valid_q && !out_stall) |=> (out_valid_q && !skid_full_q))
		else $error("skid word not moved to output");

endmodule

// File: sv/psd_front.sv
// Front stages: differences, products, dot and cross terms, case pick, cross squared, numerator split.
module psd_front import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW,
	localparam int RW = PW + 2 * FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] e_x,
	input  logic signed [COORD_WIDTH-1:0] e_y,
	output psd_ctl_t                      ctl,
	output logic [PW-1:0]                 rem0,
	output logic [RW-1:0]                 num0,
	output logic [PW-1:0]                 den,
	output logic [PW-1:0]                 s_sel
);

	logic v_s1, v_s2, v_s3;
	psd_ctl_t ctl_s4, ctl_s5, ctl_s6;

	logic signed [DW-1:0] abx_s1, aby_s1, bex_s1, bey_s1, aex_s1, aey_s1;
	logic signed [PW-1:0] db1_s2, db2_s2, da1_s2, da2_s2;
	logic signed [PW-1:0] sb1_s2, sb2_s2, sa1_s2, sa2_s2;
	logic signed [PW-1:0] c1_s2, c2_s2, l1_s2, l2_s2;
	logic signed [PW:0]   dot_b_s3, dot_a_s3, cr_s3;
	logic [PW-1:0]        s_be_s3, s_ae_s3, len2_s3;
	logic [PW-1:0]        mag_s4, len2_s4, ssel_s4;
	logic [PW-1:0]        hh_s5, hl_s5, ll_s5, len2_s5, ssel_s5;
	logic [PW-1:0]        rem_s6, len2_s6, ssel_s6;
	logic [RW-1:0]        num_s6;

	nearest_case_t kase_c;
	logic signed [PW:0]   cr_abs_c;
	logic [2*PW-1:0]      cr2_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			ctl_s4 <= '{valid: v_s3, kase: kase_c};
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_comb begin
		if (dot_b_s3 > 0)
			kase_c = CASE_BEYOND_B;
		else if (dot_a_s3 < 0)
			kase_c = CASE_BEFORE_A;
		else if (len2_s3 == '0)
			kase_c = CASE_DEGEN;
		else
			kase_c = CASE_PERP;
	end

	assign cr_abs_c = (cr_s3 < 0) ? -cr_s3 : cr_s3;
	assign cr2_c = ((2*PW)'(hh_s5) << PW) + ((2*PW)'(hl_s5) << (DW + 1)) + (2*PW)'(ll_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: vector differences
			abx_s1 <= DW'(b_x) - DW'(a_x);
			aby_s1 <= DW'(b_y) - DW'(a_y);
			bex_s1 <= DW'(e_x) - DW'(b_x);
			bey_s1 <= DW'(e_y) - DW'(b_y);
			aex_s1 <= DW'(e_x) - DW'(a_x);
			aey_s1 <= DW'(e_y) - DW'(a_y);
			// s2: products
			db1_s2 <= abx_s1 * bex_s1;
			db2_s2 <= aby_s1 * bey_s1;
			da1_s2 <= abx_s1 * aex_s1;
			da2_s2 <= aby_s1 * aey_s1;
			sb1_s2 <= bex_s1 * bex_s1;
			sb2_s2 <= bey_s1 * bey_s1;
			sa1_s2 <= aex_s1 * aex_s1;
			sa2_s2 <= aey_s1 * aey_s1;
			c1_s2  <= abx_s1 * aey_s1;
			c2_s2  <= aby_s1 * aex_s1;
			l1_s2  <= abx_s1 * abx_s1;
			l2_s2  <= aby_s1 * aby_s1;
			// s3: sums
			dot_b_s3 <= (PW+1)'(db1_s2) + (PW+1)'(db2_s2);
			dot_a_s3 <= (PW+1)'(da1_s2) + (PW+1)'(da2_s2);
			cr_s3    <= (PW+1)'(c1_s2) - (PW+1)'(c2_s2);
			s_be_s3  <= $unsigned(sb1_s2) + $unsigned(sb2_s2);
			s_ae_s3  <= $unsigned(sa1_s2) + $unsigned(sa2_s2);
			len2_s3  <= $unsigned(l1_s2) + $unsigned(l2_s2);
			// s4: case pick, |cross|
			mag_s4  <= cr_abs_c[PW-1:0];
			len2_s4 <= len2_s3;
			ssel_s4 <= (kase_c == CASE_BEYOND_B) ? s_be_s3 : s_ae_s3;
			// s5: cross squared as partial products
			hh_s5   <= PW'(mag_s4[PW-1:DW]) * PW'(mag_s4[PW-1:DW]);
			hl_s5   <= PW'(mag_s4[PW-1:DW]) * PW'(mag_s4[DW-1:0]);
			ll_s5   <= PW'(mag_s4[DW-1:0]) * PW'(mag_s4[DW-1:0]);
			len2_s5 <= len2_s4;
			ssel_s5 <= ssel_s4;
			// s6: scaled numerator split for the divider
			rem_s6  <= cr2_c[2*PW-1:PW];
			num_s6  <= RW'(cr2_c[PW-1:0]) << (2 * FRAC_BITS);
			len2_s6 <= len2_s5;
			ssel_s6 <= ssel_s5;
		end
	end

	assign ctl   = ctl_s6;
	assign rem0  = rem_s6;
	assign num0  = num_s6;
	assign den   = len2_s6;
	assign s_sel = ssel_s6;

endmodule

// File: sv/psd_div_cell.sv
// One restoring divide step: one quotient bit per cell.
module psd_div_cell import psd_pkg::*; #(
	parameter int SW   = 34,
	parameter int RW   = 50,
	parameter int SB_W = 34
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  psd_ctl_t        ctl_i,
	input  logic [SW-1:0]   rem_i,
	input  logic [RW-1:0]   num_i,
	input  logic [RW-1:0]   quot_i,
	input  logic [SW-1:0]   den_i,
	input  logic [SB_W-1:0] sb_i,
	output psd_ctl_t        ctl_o,
	output logic [SW-1:0]   rem_o,
	output logic [RW-1:0]   num_o,
	output logic [RW-1:0]   quot_o,
	output logic [SW-1:0]   den_o,
	output logic [SB_W-1:0] sb_o
);

	logic [SW:0] trial;
	logic [SW:0] diff;
	logic        ge;

	assign trial = {rem_i, num_i[RW-1]};
	assign ge    = trial >= {1'b0, den_i};
	assign diff  = trial - {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_o <= '0;
		else if (en)
			ctl_o <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[SW-1:0] : trial[SW-1:0];
			num_o  <= num_i << 1;
			quot_o <= {quot_i[RW-2:0], ge};
			den_o  <= den_i;
			sb_o   <= sb_i;
		end
	end

endmodule

// File: sv/psd_sqrt_cell.sv
// One digit-recurrence square root step: one root bit per cell.
module psd_sqrt_cell import psd_pkg::*; #(
	parameter int QW    = 25,
	parameter int RAD_W = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  psd_ctl_t         ctl_i,
	input  logic [RAD_W-1:0] rad_i,
	input  logic [QW:0]      rem_i,
	input  logic [QW-1:0]    root_i,
	output psd_ctl_t         ctl_o,
	output logic [RAD_W-1:0] rad_o,
	output logic [QW:0]      rem_o,
	output logic [QW-1:0]    root_o
);

	logic [QW+2:0] cur;
	logic [QW+2:0] trial;
	logic [QW+2:0] diff;
	logic          ge;

	assign cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign ge    = cur >= trial;
	assign diff  = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_o <= '0;
		else if (en)
			ctl_o <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= ge ? diff[QW:0] : cur[QW:0];
			root_o <= {root_i[QW-2:0], ge};
		end
	end

endmodule
